@@ sv/ufd_pkg.sv @@
// Shared types, constants and CRC helper for the frame deframer.
package ufd_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Configuration register indexes (byte address / 4)
  localparam logic [1:0] REG_SOF1    = 2'd0;
  localparam logic [1:0] REG_SOF2    = 2'd1;
  localparam logic [1:0] REG_MAX_LEN = 2'd2;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_END     = 1'b1;

  typedef enum logic [3:0] {
    PH_SOF1    = 4'd0,
    PH_SOF2    = 4'd1,
    PH_TYPE    = 4'd2,
    PH_SEQ_H   = 4'd3,
    PH_SEQ_L   = 4'd4,
    PH_LEN_H   = 4'd5,
    PH_LEN_L   = 4'd6,
    PH_PAYLOAD = 4'd7,
    PH_CRC_H   = 4'd8,
    PH_CRC_L   = 4'd9
  } phase_t;

  typedef struct packed {
    logic [7:0]  start_byte_one;
    logic [7:0]  start_byte_two;
    logic [15:0] max_payload_length;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic        result_kind;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [7:0]  frame_type;
    logic [15:0] sequence_number;
    logic [15:0] payload_length;
    logic        crc_good;
  } result_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] held_length;
  } status_t;

  // CRC-16/CCITT-FALSE, one byte, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

@@ sv/ufd_parser.sv @@
// Frame parser: phase machine, header capture, running CRC and result build.
module ufd_parser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  logic [7:0]       rx_byte,
  input  ufd_pkg::cfg_t    cfg,
  output ufd_pkg::result_t res,
  output ufd_pkg::status_t status
);

  ufd_pkg::phase_t phase_r, phase_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [15:0] seq_r, seq_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  crc_hi_r, crc_hi_nxt;
  logic [15:0] crc_fed;
  logic [15:0] cnt_inc;
  logic [15:0] len_full;

  assign crc_fed  = ufd_pkg::crc16_byte(crc_r, rx_byte);
  assign cnt_inc  = cnt_r + 16'd1;
  assign len_full = {len_r[15:8], rx_byte};

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (in_fire) begin
      case (phase_r)
        ufd_pkg::PH_SOF2:
          phase_nxt = (rx_byte == cfg.start_byte_two) ? ufd_pkg::PH_TYPE : ufd_pkg::PH_SOF1;
        ufd_pkg::PH_TYPE:  phase_nxt = ufd_pkg::PH_SEQ_H;
        ufd_pkg::PH_SEQ_H: phase_nxt = ufd_pkg::PH_SEQ_L;
        ufd_pkg::PH_SEQ_L: phase_nxt = ufd_pkg::PH_LEN_H;
        ufd_pkg::PH_LEN_H: phase_nxt = ufd_pkg::PH_LEN_L;
        ufd_pkg::PH_LEN_L: begin
          if (len_full > cfg.max_payload_length)
            phase_nxt = ufd_pkg::PH_SOF1;
          else if (len_full != 16'd0)
            phase_nxt = ufd_pkg::PH_PAYLOAD;
          else
            phase_nxt = ufd_pkg::PH_CRC_H;
        end
        ufd_pkg::PH_PAYLOAD: begin
          if (cnt_inc >= len_r || cnt_inc == 16'd0)
            phase_nxt = ufd_pkg::PH_CRC_H;
        end
        ufd_pkg::PH_CRC_H: phase_nxt = ufd_pkg::PH_CRC_L;
        ufd_pkg::PH_CRC_L: phase_nxt = ufd_pkg::PH_SOF1;
        default:
          phase_nxt = (rx_byte == cfg.start_byte_one) ? ufd_pkg::PH_SOF2 : ufd_pkg::PH_SOF1;
      endcase
    end
  end

  // held fields and result
  always_comb begin
    type_nxt   = type_r;
    seq_nxt    = seq_r;
    len_nxt    = len_r;
    cnt_nxt    = cnt_r;
    crc_nxt    = crc_r;
    crc_hi_nxt = crc_hi_r;
    res        = '0;
    if (in_fire) begin
      case (phase_r)
        ufd_pkg::PH_TYPE: begin
          type_nxt = rx_byte;
          crc_nxt  = ufd_pkg::crc16_byte(ufd_pkg::CRC_INIT, rx_byte);
        end
        ufd_pkg::PH_SEQ_H: begin
          seq_nxt = {rx_byte, 8'h00};
          crc_nxt = crc_fed;
        end
        ufd_pkg::PH_SEQ_L: begin
          seq_nxt = {seq_r[15:8], rx_byte};
          crc_nxt = crc_fed;
        end
        ufd_pkg::PH_LEN_H: begin
          len_nxt = {rx_byte, 8'h00};
          crc_nxt = crc_fed;
        end
        ufd_pkg::PH_LEN_L: begin
          len_nxt = len_full;
          crc_nxt = crc_fed;
          cnt_nxt = 16'd0;
        end
        ufd_pkg::PH_PAYLOAD: begin
          crc_nxt           = crc_fed;
          cnt_nxt           = cnt_inc;
          res.valid         = 1'b1;
          res.result_kind   = ufd_pkg::KIND_PAYLOAD;
          res.payload_byte  = rx_byte;
          res.payload_index = cnt_r;
        end
        ufd_pkg::PH_CRC_H: crc_hi_nxt = rx_byte;
        ufd_pkg::PH_CRC_L: begin
          res.valid           = 1'b1;
          res.result_kind     = ufd_pkg::KIND_END;
          res.frame_type      = type_r;
          res.sequence_number = seq_r;
          res.payload_length  = len_r;
          res.crc_good        = ({crc_hi_r, rx_byte} == crc_r);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= ufd_pkg::PH_SOF1;
      type_r   <= '0;
      seq_r    <= '0;
      len_r    <= '0;
      cnt_r    <= '0;
      crc_r    <= ufd_pkg::CRC_INIT;
      crc_hi_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      type_r   <= type_nxt;
      seq_r    <= seq_nxt;
      len_r    <= len_nxt;
      cnt_r    <= cnt_nxt;
      crc_r    <= crc_nxt;
      crc_hi_r <= crc_hi_nxt;
    end
  end

  assign status.phase       = phase_r;
  assign status.held_length = len_r;

endmodule

@@ sv/uart_frame_deframer_crc16.sv @@
// Top level: stream ports, APB register file, output register and checks.
// Deframes a received byte stream (two start bytes, type, sequence, length, payload,
// CRC-16/CCITT-FALSE over type through payload) at one byte per clock. Each byte beat
// is parsed in the cycle it is accepted, and any result it causes (one per payload
// byte, one verdict at the last CRC byte) sits in the output register from the next
// cycle. in_tready drops only while that register holds a beat the sink has not
// taken. Oversized frames are dropped without a result; bad-CRC frames still get an
// end beat with crc_good low. Registers: 0x0 start byte one, 0x4 start byte two,
// 0x8 max payload length; write them only while the link is idle.
module uart_frame_deframer_crc16 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] payload_byte, [23:8] payload_index, [31:24] frame_type,
  // [47:32] sequence_number, [63:48] payload_length, [64] crc_good, [71:65] zero
  output logic [71:0] out_tdata,
  output logic        out_tuser,  // [0] result_kind
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  ufd_pkg::cfg_t    cfg_r;
  ufd_pkg::result_t res;
  ufd_pkg::status_t status;
  logic             in_fire;
  logic             cfg_wr;
  logic [1:0]       cfg_idx;
  logic             out_valid_r, out_valid_nxt;
  logic [71:0]      out_data_r;
  logic             out_kind_r;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[3:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte_one     <= 8'hAA;
      cfg_r.start_byte_two     <= 8'h55;
      cfg_r.max_payload_length <= 16'd256;
    end else if (cfg_wr) begin
      case (cfg_idx)
        ufd_pkg::REG_SOF1:    cfg_r.start_byte_one     <= cfg_pwdata[7:0];
        ufd_pkg::REG_SOF2:    cfg_r.start_byte_two     <= cfg_pwdata[7:0];
        ufd_pkg::REG_MAX_LEN: cfg_r.max_payload_length <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      ufd_pkg::REG_SOF1:    cfg_prdata = {24'd0, cfg_r.start_byte_one};
      ufd_pkg::REG_SOF2:    cfg_prdata = {24'd0, cfg_r.start_byte_two};
      ufd_pkg::REG_MAX_LEN: cfg_prdata = {16'd0, cfg_r.max_payload_length};
      default:              cfg_prdata = 32'd0;
    endcase
  end

  // output register frees up in the same cycle it is drained
  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;

  ufd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .rx_byte (in_tdata),
    .cfg     (cfg_r),
    .res     (res),
    .status  (status)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready)
      out_valid_nxt = 1'b0;
    if (res.valid)
      out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else
      out_valid_r <= out_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_kind_r <= res.result_kind;
      out_data_r <= {7'd0, res.crc_good, res.payload_length, res.sequence_number,
                     res.frame_type, res.payload_index, res.payload_byte};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;

  // an end verdict always returns the parser to hunting for a start byte
  a_end_resync: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.result_kind == ufd_pkg::KIND_END) |=> status.phase == ufd_pkg::PH_SOF1)
    else $error("parser did not resync after end of frame");

  // forwarded payload index stays inside the declared length
  a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res.result_kind == ufd_pkg::KIND_PAYLOAD) |->
      res.payload_index < status.held_length)
    else $error("payload index beyond frame length");

  // input stalls only behind a full, stalled output register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_valid_r && !out_tready))
    else $error("input stalled without output backpressure");

  // a result is never produced unless a beat was accepted
  a_result_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
    res.valid |-> in_fire)
    else $error("result without accepted input beat");

endmodule
